[hdl/srru_pkg.sv]
// Shared constants and helpers for the subset rank/unrank block.
// No dependencies; used by srru_pascal, subset_rank_unrank and the testbench.
package srru_pkg;

  localparam int CFG_W  = 6;
  localparam int DATA_W = 32;

  localparam logic [CFG_W-1:0] SET_SIZE_RST = 6'd32;

  localparam logic OP_RANK   = 1'b0;
  localparam logic OP_UNRANK = 1'b1;

  // bits needed to hold a count 0 .. set_bits
  function automatic int idx_w(input int set_bits);
    return $clog2(set_bits + 1);
  endfunction

endpackage

[hdl/srru_pascal.sv]
// Pascal triangle memory: C(a,b) for 0 <= a,b <= SET_BITS, two registered read ports.
// Filled row by row after reset, each entry read in B_RD and written in B_WR. Depends on srru_pkg.
module srru_pascal #(
  parameter int SET_BITS = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  output logic                                   ready_o,
  input  logic [srru_pkg::idx_w(SET_BITS)-1:0]   rd0_a_i,
  input  logic [srru_pkg::idx_w(SET_BITS)-1:0]   rd0_b_i,
  input  logic [srru_pkg::idx_w(SET_BITS)-1:0]   rd1_a_i,
  input  logic [srru_pkg::idx_w(SET_BITS)-1:0]   rd1_b_i,
  output logic [SET_BITS-1:0]                    rd0_data_o,
  output logic [SET_BITS-1:0]                    rd1_data_o
);

  localparam int IW    = srru_pkg::idx_w(SET_BITS);
  localparam int K     = SET_BITS + 1;
  localparam int DEPTH = K * K;
  localparam int AW    = $clog2(DEPTH);
  localparam int W     = SET_BITS;
  localparam logic [IW-1:0] TOP = IW'(SET_BITS);

  localparam logic [1:0] B_RD   = 2'd0;
  localparam logic [1:0] B_WR   = 2'd1;
  localparam logic [1:0] B_DONE = 2'd2;

  // out-of-table coordinates map to entry 0
  function automatic logic [AW-1:0] tab_addr(input logic [IW-1:0] a, input logic [IW-1:0] b);
    logic [AW-1:0] addr;
    if (a > TOP || b > TOP) begin
      addr = '0;
    end else begin
      addr = AW'(int'(a) * K + int'(b));
    end
    return addr;
  endfunction

  logic [1:0]    bst_q, bst_d;
  logic [IW-1:0] ba_q, ba_d, bb_q, bb_d;
  logic [W-1:0]  last_q, last_d;
  logic [W-1:0]  mem [DEPTH];
  logic [W-1:0]  rd0_q, rd1_q;
  logic [AW-1:0] raddr0, raddr1, waddr;
  logic [W-1:0]  wdata;
  logic          we;

  always_comb begin
    bst_d  = bst_q;
    ba_d   = ba_q;
    bb_d   = bb_q;
    last_d = last_q;
    we     = 1'b0;
    wdata  = rd0_q + last_q;
    waddr  = tab_addr(ba_q, bb_q);
    raddr0 = tab_addr(rd0_a_i, rd0_b_i);
    raddr1 = tab_addr(rd1_a_i, rd1_b_i);
    unique case (bst_q)
      B_RD: begin
        raddr0 = tab_addr((ba_q == '0) ? ba_q : ba_q - 1'b1, bb_q);
        bst_d  = B_WR;
      end
      B_WR: begin
        we = 1'b1;
        if (bb_q == '0) begin
          wdata  = W'(1);
          last_d = W'(1);
        end else if (ba_q == '0) begin
          wdata  = '0;
          last_d = rd0_q;
        end else begin
          last_d = rd0_q;
        end
        if (bb_q == TOP) begin
          bb_d = '0;
          if (ba_q == TOP) begin
            bst_d = B_DONE;
          end else begin
            ba_d  = ba_q + 1'b1;
            bst_d = B_RD;
          end
        end else begin
          bb_d  = bb_q + 1'b1;
          bst_d = B_RD;
        end
      end
      B_DONE: begin
      end
      default: begin
        bst_d = B_RD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bst_q <= B_RD;
      ba_q  <= '0;
      bb_q  <= '0;
    end else begin
      bst_q <= bst_d;
      ba_q  <= ba_d;
      bb_q  <= bb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd0_q <= mem[raddr0];
    rd1_q <= mem[raddr1];
  end

  assign ready_o    = (bst_q == B_DONE);
  assign rd0_data_o = rd0_q;
  assign rd1_data_o = rd1_q;

endmodule

[hdl/subset_rank_unrank.sv]
// Subset rank/unrank in the combinatorial number system (size, then colex order).
// Rank: mask scan (S_RSCAN), size sum (S_RSUM), then output (S_FIN).
// Unrank: S_USTART, S_UCNT, S_USEL, S_FIN; an out-of-range index skips to S_FIN.
// One item at a time: every step reads the one shared Pascal table.
// After reset the table is built with s_axis_tready low.
// Reset: set_size = 32, no result pending. Depends on srru_pkg and srru_pascal.
module subset_rank_unrank #(
  parameter int SET_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [srru_pkg::CFG_W-1:0] cfg_wdata_i,   // set_size
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [31:0]                s_axis_tdata,  // [31:0] value
  input  logic [0:0]                 s_axis_tuser,  // [0] op
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [31:0]                m_axis_tdata,  // [31:0] result
  output logic [0:0]                 m_axis_tuser   // [0] bad_index
);

  localparam int W  = SET_BITS;
  localparam int IW = srru_pkg::idx_w(SET_BITS);
  localparam int XW = (SET_BITS > srru_pkg::DATA_W) ? SET_BITS : srru_pkg::DATA_W;
  localparam logic [IW-1:0] TOP = IW'(SET_BITS);
  localparam logic [srru_pkg::CFG_W-1:0] TOP_CFG = srru_pkg::CFG_W'(SET_BITS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RSCAN  = 3'd1;
  localparam logic [2:0] S_RSUM   = 3'd2;
  localparam logic [2:0] S_USTART = 3'd3;
  localparam logic [2:0] S_UCNT   = 3'd4;
  localparam logic [2:0] S_USEL   = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic [srru_pkg::CFG_W-1:0] cfg_q;
  logic [2:0]    state_q, state_d;
  logic [IW-1:0] n_q, n_d, idx_q, idx_d, cnt_q, cnt_d;
  logic [W-1:0]  data_q, data_d, acc_q, acc_d;
  logic          pend_q, pend_d, took_q, took_d, bad_q, bad_d;
  logic          out_valid_q, out_valid_d, out_bad_q, out_bad_d;
  logic [31:0]   out_data_q, out_data_d;

  logic          tab_ready;
  logic [IW-1:0] la0, lb0, la1, lb1;
  logic [W-1:0]  rd0, rd1, add_in, sel_c;
  logic [IW-1:0] n_in;
  logic [XW-1:0] value_x, lowmask, in_mask, acc_x;
  logic          in_high, in_xfer;

  srru_pascal #(
    .SET_BITS (SET_BITS)
  ) u_pascal (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ready_o    (tab_ready),
    .rd0_a_i    (la0),
    .rd0_b_i    (lb0),
    .rd1_a_i    (la1),
    .rd1_b_i    (lb1),
    .rd0_data_o (rd0),
    .rd1_data_o (rd1)
  );

  assign n_in    = (cfg_q > TOP_CFG) ? TOP : IW'(cfg_q);
  assign value_x = XW'(s_axis_tdata);
  assign lowmask = ~({XW{1'b1}} << n_in);
  assign in_mask = value_x & lowmask;
  assign in_high = |(value_x & ~lowmask);
  assign acc_x   = XW'(acc_q);
  assign add_in  = pend_q ? rd0 : '0;
  assign sel_c   = took_q ? rd1 : rd0;

  assign s_axis_tready = (state_q == S_IDLE) && tab_ready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    data_d      = data_q;
    acc_d       = acc_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    pend_d      = 1'b0;
    took_d      = took_q;
    bad_d       = bad_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_bad_d   = out_bad_q;
    la0         = '0;
    lb0         = '0;
    la1         = '0;
    lb1         = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          n_d    = n_in;
          acc_d  = '0;
          idx_d  = '0;
          cnt_d  = '0;
          took_d = 1'b0;
          if (s_axis_tuser[0] == srru_pkg::OP_RANK) begin
            data_d  = in_mask[W-1:0];
            bad_d   = 1'b0;
            state_d = S_RSCAN;
          end else begin
            data_d  = value_x[W-1:0];
            bad_d   = in_high;
            state_d = in_high ? S_FIN : S_USTART;
          end
        end
      end
      // walk mask bits upward, fetch C(e, j) for the j-th set bit
      S_RSCAN: begin
        acc_d = acc_q + add_in;
        if (idx_q != n_q) begin
          data_d = data_q >> 1;
          idx_d  = idx_q + 1'b1;
          if (data_q[0]) begin
            cnt_d  = cnt_q + 1'b1;
            la0    = idx_q;
            lb0    = cnt_q + 1'b1;
            pend_d = 1'b1;
          end
        end else begin
          idx_d   = '0;
          state_d = S_RSUM;
        end
      end
      // add C(n, j) for every size below the subset's
      S_RSUM: begin
        acc_d = acc_q + add_in;
        if (idx_q != cnt_q) begin
          la0    = n_q;
          lb0    = idx_q;
          pend_d = 1'b1;
          idx_d  = idx_q + 1'b1;
        end else begin
          state_d = S_FIN;
        end
      end
      S_USTART: begin
        la0     = n_q;
        lb0     = '0;
        state_d = S_UCNT;
      end
      // find subset size; on a pass the next lookup is C(n, cnt+1), else C(n-1, cnt)
      S_UCNT: begin
        if (cnt_q <= n_q && rd0 <= data_q) begin
          data_d = data_q - rd0;
          cnt_d  = cnt_q + 1'b1;
          la0    = n_q;
          lb0    = cnt_q + 1'b1;
        end else begin
          idx_d   = n_q;
          took_d  = 1'b0;
          la0     = n_q - 1'b1;
          lb0     = cnt_q;
          state_d = S_USEL;
        end
      end
      // greedy colex decode; both candidate counts are fetched ahead
      S_USEL: begin
        if (cnt_q == '0 || idx_q == '0) begin
          state_d = S_FIN;
        end else begin
          if (sel_c <= data_q) begin
            data_d = data_q - sel_c;
            acc_d  = acc_q | (W'(1) << (idx_q - 1'b1));
            cnt_d  = cnt_q - 1'b1;
            took_d = 1'b1;
          end else begin
            took_d = 1'b0;
          end
          idx_d = idx_q - 1'b1;
          la0   = (idx_q - 1'b1) - 1'b1;
          lb0   = cnt_q;
          la1   = (idx_q - 1'b1) - 1'b1;
          lb1   = cnt_q - 1'b1;
        end
      end
      S_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = acc_x[31:0];
          out_bad_d   = bad_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= srru_pkg::SET_SIZE_RST;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      took_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      took_q      <= took_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    data_q     <= data_d;
    acc_q      <= acc_d;
    bad_q      <= bad_d;
    out_data_q <= out_data_d;
    out_bad_q  <= out_bad_d;
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_bad_q;

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_bad_q |-> out_data_q == '0)
    else $error("flagged index with nonzero result");

  a_rank_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RSCAN || state_q == S_RSUM) |-> !bad_q)
    else $error("rank carries bad_index");

  a_sel_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_USEL |-> cnt_q <= idx_q)
    else $error("more bits left than positions");

  a_sel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_USEL |-> (acc_q >> n_q) == '0)
    else $error("unrank mask bit outside universe");

  a_fin_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN && out_valid_q && !m_axis_tready |=> state_q == S_FIN)
    else $error("result left finish while output busy");

endmodule

[tb/tb_subset_rank_unrank.sv]
// Self-checking testbench for subset_rank_unrank: ranks and unranks subsets
// against a local combinatorial-number-system predictor under random stalls.
// Depends on srru_pkg and the subset_rank_unrank RTL.
`timescale 1ns / 1ps

module tb_subset_rank_unrank;

  localparam int NMAX        = 32;
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic [31:0] result;
    logic        bad_index;
  } subset_res_t;

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       cfg_we_i      = 1'b0;
  logic [srru_pkg::CFG_W-1:0] cfg_wdata_i   = '0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [31:0]                s_axis_tdata  = '0;
  logic [0:0]                 s_axis_tuser  = '0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [31:0]                m_axis_tdata;
  logic [0:0]                 m_axis_tuser;

  subset_res_t                expected_q[$];
  subset_res_t                head_res;
  logic [srru_pkg::CFG_W-1:0] size_shadow   = srru_pkg::SET_SIZE_RST;
  int                         fail_count    = 0;
  int                         cycle_count   = 0;
  int                         burst_left    = 0;
  int                         stall_left    = 0;
  int                         stall_mode    = 0;

  subset_rank_unrank #(.SET_BITS(NMAX)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // exact C(a,b); zero when b > a
  function automatic logic [63:0] choose(input int a, input int b);
    logic [63:0] c;
    if (b < 0 || b > a) return 64'd0;
    c = 64'd1;
    for (int i = 0; i < b; i++) c = c * (a - i) / (i + 1);
    return c;
  endfunction

  function automatic int universe_n();
    return (size_shadow > NMAX) ? NMAX : int'(size_shadow);
  endfunction

  function automatic subset_res_t predict_subset(input logic op, input logic [31:0] value);
    subset_res_t r;
    logic [63:0] acc, v, mask, c;
    int          n, cnt, k;
    n = universe_n();
    r = '0;
    if (op == srru_pkg::OP_RANK) begin
      mask = {32'd0, value} & ((64'd1 << n) - 64'd1);
      cnt  = $countones(mask);
      acc  = 64'd0;
      for (int j = 0; j < cnt; j++) acc += choose(n, j);
      k = 0;
      for (int e = 0; e < n; e++) begin
        if (mask[e]) begin
          k++;
          acc += choose(e, k);
        end
      end
      r.result = acc[31:0];
    end else if ({32'd0, value} >= (64'd1 << n)) begin
      r.bad_index = 1'b1;
    end else begin
      v   = {32'd0, value};
      cnt = 0;
      while (cnt <= n && choose(n, cnt) <= v) begin
        v -= choose(n, cnt);
        cnt++;
      end
      mask = 64'd0;
      for (int e = n - 1; e >= 0 && cnt > 0; e--) begin
        c = choose(e, cnt);
        if (c <= v) begin
          v -= c;
          mask[e] = 1'b1;
          cnt--;
        end
      end
      r.result = mask[31:0];
    end
    return r;
  endfunction

  // receiver: m_axis_tready follows one of four random stall modes, chosen anew when each run ends
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= ($urandom_range(0, 1) == 1);
      end
      2: begin
        m_axis_tready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        m_axis_tready <= ($urandom_range(0, 7) != 0);
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected transfer: result %h bad_index %b", $time,
                 m_axis_tdata, m_axis_tuser);
        fail_count++;
      end else begin
        head_res = expected_q.pop_front();
        if (m_axis_tdata !== head_res.result) begin
          $display("%0t result mismatch: expected %h actual %h", $time,
                   head_res.result, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tuser[0] !== head_res.bad_index) begin
          $display("%0t bad_index mismatch: expected %b actual %b", $time,
                   head_res.bad_index, m_axis_tuser[0]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_subset_rank_unrank NOT OK");
      $finish;
    end
  end

  task automatic send_subset(input logic op, input logic [31:0] value);
    int gap;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_q.push_back(predict_subset(op, value));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_universe(input logic [srru_pkg::CFG_W-1:0] size);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= size;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    size_shadow = size;
  endtask

  function automatic logic [31:0] rand_mask();
    logic [31:0] a, b;
    a = $urandom();
    b = $urandom();
    case ($urandom_range(0, 5))
      0: return a & b;
      1: return a | b;
      2: return a & b & $urandom();
      3: return 32'd1 << $urandom_range(0, 31);
      4: return ~(32'd1 << $urandom_range(0, 31));
      default: return a;
    endcase
  endfunction

  // mostly in-range indexes spread evenly over subset sizes
  function automatic logic [31:0] rand_index();
    logic [63:0] base, span, r;
    int          n, k;
    n = universe_n();
    r = {$urandom(), $urandom()};
    if ($urandom_range(0, 99) < 85 || n >= 32) begin
      k    = $urandom_range(0, n);
      base = 64'd0;
      for (int j = 0; j < k; j++) base += choose(n, j);
      span = choose(n, k);
      case ($urandom_range(0, 5))
        0: return base[31:0];
        1: return 32'(base + span - 64'd1);
        default: return 32'(base + r % span);
      endcase
    end
    case ($urandom_range(0, 2))
      0: return 32'd1 << n;
      1: return 32'hFFFF_FFFF;
      default: return 32'((64'd1 << n) + r % ((64'd1 << 32) - (64'd1 << n)));
    endcase
  endfunction

  task automatic test_directed_extremes();
    send_subset(srru_pkg::OP_RANK,   32'h0000_0000);
    send_subset(srru_pkg::OP_RANK,   32'hFFFF_FFFF);
    send_subset(srru_pkg::OP_RANK,   32'h0000_0001);
    send_subset(srru_pkg::OP_RANK,   32'h8000_0000);
    send_subset(srru_pkg::OP_UNRANK, 32'h0000_0000);
    send_subset(srru_pkg::OP_UNRANK, 32'hFFFF_FFFF);
    send_subset(srru_pkg::OP_UNRANK, 32'h0000_0001);
    send_subset(srru_pkg::OP_UNRANK, 32'h8000_0000);
    // empty universe
    set_universe(6'd0);
    send_subset(srru_pkg::OP_RANK,   32'hFFFF_FFFF);
    send_subset(srru_pkg::OP_UNRANK, 32'h0000_0000);
    send_subset(srru_pkg::OP_UNRANK, 32'h0000_0001);
    // mask bits above the universe are dropped; index 2^n is out of range
    set_universe(6'd5);
    send_subset(srru_pkg::OP_RANK,   32'hFFFF_FFE0);
    send_subset(srru_pkg::OP_RANK,   32'hFFFF_FFFF);
    send_subset(srru_pkg::OP_UNRANK, 32'd31);
    send_subset(srru_pkg::OP_UNRANK, 32'd32);
    send_subset(srru_pkg::OP_UNRANK, 32'hFFFF_FFFF);
    // sizes past the universe limit clamp to it
    set_universe(6'd63);
    send_subset(srru_pkg::OP_RANK,   32'hFFFF_FFFF);
    send_subset(srru_pkg::OP_UNRANK, 32'hFFFF_FFFF);
    set_universe(6'd40);
    send_subset(srru_pkg::OP_RANK,   32'h5555_AAAA);
    send_subset(srru_pkg::OP_UNRANK, 32'h1234_5678);
  endtask

  task automatic test_rank_random();
    logic [srru_pkg::CFG_W-1:0] sizes[5] = '{6'd32, 6'd0, 6'd1, 6'd16, 6'd63};
    foreach (sizes[i]) begin
      set_universe(sizes[i]);
      repeat (100) send_subset(srru_pkg::OP_RANK, rand_mask());
    end
  endtask

  task automatic test_unrank_random();
    logic [srru_pkg::CFG_W-1:0] sizes[5] = '{6'd32, 6'd1, 6'd2, 6'd20, 6'd33};
    foreach (sizes[i]) begin
      set_universe(sizes[i]);
      repeat (100) send_subset(srru_pkg::OP_UNRANK, rand_index());
    end
  endtask

  task automatic test_mixed_random();
    logic [srru_pkg::CFG_W-1:0] sizes[5];
    sizes = '{6'd31, 6'd32, 6'($urandom_range(0, 63)), 6'($urandom_range(3, 30)),
              6'($urandom_range(0, 63))};
    foreach (sizes[i]) begin
      set_universe(sizes[i]);
      repeat (90) begin
        if ($urandom_range(0, 1)) send_subset(srru_pkg::OP_UNRANK, rand_index());
        else                      send_subset(srru_pkg::OP_RANK, rand_mask());
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_extremes();
    test_rank_random();
    test_unrank_random();
    test_mixed_random();
    wait_idle();
    repeat (2 * NMAX + 10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_subset_rank_unrank OK");
    end else begin
      $display("tb_subset_rank_unrank NOT OK");
    end
    $finish;
  end

endmodule
